@@ rtl/assert_macros.svh @@
// Assertion macros used by the checker module of the project.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every clock edge, reset included.
`define ASSERT_CLK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ rtl/wbss_pkg.sv @@
// Types and constants of the wildcard byte signature scanner.
`default_nettype none

package wbss_pkg;

  // Configuration port shape
  localparam int CFG_DATA_W  = 64;
  localparam int CFG_INDEX_W = 3;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] CFG_SIG_0_7   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIG_8_15  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIG_16_23 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_SIG_24_31 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_WILDCARD  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_LENGTH    = 3'd5;

  // Register storage limits
  localparam int SIG_WORDS  = 4;
  localparam int SIG_BYTES  = 32;
  localparam int LEN_W      = 6;
  localparam int OFFSET_W   = 32;

  typedef logic [7:0]          byte_t;
  typedef logic [OFFSET_W-1:0] offset_t;
  typedef logic [LEN_W-1:0]    len_t;

endpackage

`default_nettype wire

@@ rtl/wildcard_byte_signature_scan_unit.sv @@
// Path: an accepted item waits in the input register, then its result is registered.
// Throughput: one item per cycle unless a result stalls; the input register and result
// register decouple the two channels, and a stalled result holds the input register only.
// Reset (rst_n low, synchronous) empties both registers, clears the byte window, the
// position count and the done flag, and loads the default signature (length 1, no wildcards).
`default_nettype none

module wildcard_byte_signature_scan_unit
  import wbss_pkg::*;
#(
  parameter int MAX_SIGNATURE_BYTES = 32
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   cfg_we,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data,
  input  wire logic                   in_valid,
  output logic                        in_ready,
  input  wire logic [7:0]             in_image_byte,
  input  wire logic                   in_is_final_byte,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic                        out_found,
  output logic [OFFSET_W-1:0]         out_match_offset
);

  localparam int   IDX_W   = (MAX_SIGNATURE_BYTES > 1) ? $clog2(MAX_SIGNATURE_BYTES) : 1;
  localparam len_t MAX_LEN = LEN_W'(MAX_SIGNATURE_BYTES);

  // Configuration registers
  logic [CFG_DATA_W-1:0] sig_words_r [SIG_WORDS];
  logic [SIG_BYTES-1:0]  wild_r;
  len_t                  len_r;

  // Input register
  logic  in_valid_r;
  byte_t in_byte_r;
  logic  in_final_r;

  // Scan state
  byte_t   win_r [MAX_SIGNATURE_BYTES];
  byte_t   win_nxt [MAX_SIGNATURE_BYTES];
  offset_t pos_r;
  offset_t pos_nxt;
  logic    rep_r;

  // Result register
  logic    out_valid_r;
  logic    out_found_r;
  offset_t out_off_r;

  logic                          consume;
  len_t                          used_len;
  logic                          sat;
  logic                          pos_ge;
  logic                          hit;
  logic                          has_res;
  offset_t                       offset;
  logic [MAX_SIGNATURE_BYTES-1:0] byte_ok;

  // Take the configuration writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int w = 0; w < SIG_WORDS; w++) begin
        sig_words_r[w] <= '0;
      end
      wild_r <= '0;
      len_r  <= len_t'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_SIG_0_7:   sig_words_r[0] <= cfg_data;
        CFG_SIG_8_15:  sig_words_r[1] <= cfg_data;
        CFG_SIG_16_23: sig_words_r[2] <= cfg_data;
        CFG_SIG_24_31: sig_words_r[3] <= cfg_data;
        CFG_WILDCARD:  wild_r <= cfg_data[SIG_BYTES-1:0];
        CFG_LENGTH:    len_r  <= cfg_data[LEN_W-1:0];
        default:       ;
      endcase
    end
  end

  // Clamp the signature length into 1 .. MAX_SIGNATURE_BYTES
  always_comb begin
    if (len_r == '0) begin
      used_len = len_t'(1);
    end else if (len_r > MAX_LEN) begin
      used_len = MAX_LEN;
    end else begin
      used_len = len_r;
    end
  end

  // Advance the input register when the result side can take the outcome
  assign consume  = in_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !in_valid_r || consume;

  // Shift the newest byte into the window
  always_comb begin
    win_nxt[0] = in_byte_r;
    for (int j = 1; j < MAX_SIGNATURE_BYTES; j++) begin
      win_nxt[j] = win_r[j-1];
    end
  end

  // Count bytes, holding at the top of the range
  assign sat     = (pos_r == '1);
  assign pos_nxt = sat ? pos_r : pos_r + offset_t'(1);
  assign pos_ge  = (pos_nxt >= offset_t'(used_len));
  assign offset  = pos_nxt - offset_t'(used_len);

  // Compare each signature byte with its window byte in parallel
  for (genvar k = 0; k < MAX_SIGNATURE_BYTES; k++) begin : g_cmp
    len_t  jj;
    byte_t sig_byte;
    assign jj       = used_len - len_t'(k) - len_t'(1);
    assign sig_byte = sig_words_r[k / 8][(k % 8) * 8 +: 8];
    assign byte_ok[k] = (len_t'(k) >= used_len) || wild_r[k] ||
                        (win_nxt[jj[IDX_W-1:0]] == sig_byte);
  end

  assign hit     = !rep_r && !sat && pos_ge && (&byte_ok);
  assign has_res = hit || (!rep_r && in_final_r);

  // Control registers: item valids, window, position and done flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      pos_r       <= '0;
      rep_r       <= 1'b0;
      for (int j = 0; j < MAX_SIGNATURE_BYTES; j++) begin
        win_r[j] <= '0;
      end
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (consume && has_res) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (consume) begin
        if (in_final_r) begin
          pos_r <= '0;
          rep_r <= 1'b0;
          for (int j = 0; j < MAX_SIGNATURE_BYTES; j++) begin
            win_r[j] <= '0;
          end
        end else begin
          pos_r <= pos_nxt;
          rep_r <= rep_r || hit;
          for (int j = 0; j < MAX_SIGNATURE_BYTES; j++) begin
            win_r[j] <= win_nxt[j];
          end
        end
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_ready) begin
      in_byte_r  <= in_image_byte;
      in_final_r <= in_is_final_byte;
    end
    if (consume && has_res) begin
      out_found_r <= hit;
      out_off_r   <= hit ? offset : '0;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_found        = out_found_r;
  assign out_match_offset = out_off_r;

endmodule

`default_nettype wire

@@ rtl/wbss_checker.sv @@
// Port-level checks of the signature scanner and their bind to the top level.
`default_nettype none
`include "assert_macros.svh"

module wbss_checker
  import wbss_pkg::*;
(
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   in_ready,
  input wire logic                   out_valid,
  input wire logic                   out_ready,
  input wire logic                   out_found,
  input wire logic [OFFSET_W-1:0]    out_match_offset
);

  property p_out_hold;
    out_valid && !out_ready |=>
      out_valid && $stable(out_found) && $stable(out_match_offset);
  endproperty

  property p_in_backpressure;
    !in_ready |-> out_valid && !out_ready;
  endproperty

  property p_miss_offset;
    out_valid && !out_found |-> out_match_offset == '0;
  endproperty

  // Hold a stalled result unchanged
  `ASSERT_CLK(a_out_hold, clk, rst_n, p_out_hold, "stalled result changed")

  // Refuse an item only while a result waits downstream
  `ASSERT_CLK(a_in_backpressure, clk, rst_n, p_in_backpressure, "input stalled without back-pressure")

  // A miss carries a zero offset
  `ASSERT_CLK(a_miss_offset, clk, rst_n, p_miss_offset, "miss result with non-zero offset")

  // Drop any result after reset
  `ASSERT_CLK_ALWAYS(a_reset_empty, clk, !rst_n |=> !out_valid, "result present after reset")

endmodule

bind wildcard_byte_signature_scan_unit wbss_checker u_wbss_checker (.*);

`default_nettype wire
